// ===== hdl/ltrc_pkg.sv =====
// Shared types and constants of the left-to-right character calculator.
package ltrc_pkg;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_MOD  = 3'd5,
    OP_POW  = 3'd6
  } op_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DIV0    = 2'd1;
  localparam logic [1:0] ST_MOD0    = 2'd2;
  localparam logic [1:0] ST_BADCHAR = 2'd3;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [2:0] PH_MUL_END = 3'd2;
  localparam logic [2:0] PH_POW_END = 3'd5;

  typedef enum logic [2:0] {
    CMD_IDLE   = 3'd0,
    CMD_DIGIT  = 3'd1,
    CMD_OPER   = 3'd2,
    CMD_FINAL  = 3'd3,
    CMD_STEP   = 3'd4,
    CMD_CLEAR  = 3'd5,
    CMD_BAD    = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    RUN_NONE = 2'd0,
    RUN_DIV  = 2'd1,
    RUN_MUL  = 2'd2,
    RUN_POW  = 2'd3
  } run_t;

  typedef struct packed {
    cmd_t       cmd;
    op_t        new_op;
    logic [6:0] step;
    logic [2:0] phase;
  } ctrl_t;

  function automatic op_t op_of(input logic [7:0] c);
    unique case (c)
      CH_PLUS:  op_of = OP_ADD;
      CH_MINUS: op_of = OP_SUB;
      CH_STAR:  op_of = OP_MUL;
      CH_SLASH: op_of = OP_DIV;
      CH_PCT:   op_of = OP_MOD;
      CH_CARET: op_of = OP_POW;
      default:  op_of = OP_NONE;
    endcase
  endfunction

endpackage

// ===== hdl/ltrc_datapath.sv =====
// Datapath: operand build, running value, and the shared iterative ALU.
module ltrc_datapath
  import ltrc_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctrl_t                  ctrl,
  input  logic [7:0]             char_code,
  output logic [VALUE_WIDTH-1:0] result,
  output logic [1:0]             err,
  output run_t                   run_kind
);

  localparam int W  = VALUE_WIDTH;
  localparam int IW = $clog2(W);

  logic [W-1:0] running_value;
  logic [W-1:0] operand_value;
  op_t          pending_op;
  logic         have_first;
  logic [1:0]   error_flags;

  // iterative unit registers
  logic [W-1:0] a_r;
  logic [W-1:0] b_r;
  logic [W-1:0] acc;
  logic [W-1:0] rem;
  logic [W-1:0] quo;
  logic [W-1:0] sq;
  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;
  logic [63:0]  mp;

  logic [W-1:0]  dig_w;
  logic [W:0]    rem_sh;
  logic [W:0]    rem_sub;
  logic          a_neg;
  logic          b_neg;
  logic [IW-1:0] bit_idx;
  logic [W-1:0]  all_ones;
  logic [W-1:0]  one_w;
  logic [63:0]   mx;
  logic [63:0]   my;
  logic [31:0]   mx_part;
  logic [31:0]   my_part;
  logic [1:0]    sub;
  logic [63:0]   pp;
  logic [63:0]   mp_sum;

  assign all_ones = '1;
  assign one_w    = W'(1);
  assign a_neg    = a_r[W-1];
  assign b_neg    = b_r[W-1];
  assign bit_idx  = IW'(W - 1 - int'(ctrl.step));
  assign dig_w    = W'(operand_value * W'(10)) + W'(char_code - CH_ZERO);
  assign rem_sh   = {rem, mag_a[bit_idx]};
  assign rem_sub  = rem_sh - {1'b0, mag_b};
  assign pp       = {32'd0, mx_part} * {32'd0, my_part};
  assign mp_sum   = mp + {pp[31:0], 32'd0};

  always_comb begin
    unique case (pending_op)
      OP_DIV, OP_MOD: run_kind = RUN_DIV;
      OP_MUL:         run_kind = RUN_MUL;
      OP_POW:         run_kind = RUN_POW;
      default:        run_kind = RUN_NONE;
    endcase
  end

  // select one 32-bit partial product per cycle
  always_comb begin
    mx  = 64'(a_r);
    my  = 64'(b_r);
    sub = ctrl.phase[1:0];
    if (pending_op == OP_POW) begin
      if (ctrl.phase <= PH_MUL_END) begin
        mx = 64'(acc);
        my = 64'(acc);
      end else begin
        mx  = 64'(sq);
        my  = 64'(a_r);
        sub = 2'(ctrl.phase - 3'd3);
      end
    end
    unique case (sub)
      2'd0: begin
        mx_part = mx[31:0];
        my_part = my[31:0];
      end
      2'd1: begin
        mx_part = mx[31:0];
        my_part = my[63:32];
      end
      default: begin
        mx_part = mx[63:32];
        my_part = my[31:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_value <= '0;
      operand_value <= '0;
      pending_op    <= OP_NONE;
      have_first    <= 1'b0;
      error_flags   <= ST_OK;
    end else begin
      unique case (ctrl.cmd)
        CMD_DIGIT: operand_value <= dig_w;
        CMD_BAD: if (error_flags == ST_OK) error_flags <= ST_BADCHAR;
        CMD_CLEAR: begin
          operand_value <= '0;
          if (ctrl.new_op == OP_NONE) begin
            running_value <= '0;
            have_first    <= 1'b0;
            pending_op    <= OP_NONE;
            error_flags   <= ST_OK;
          end else begin
            running_value <= result;
            have_first    <= 1'b1;
            pending_op    <= ctrl.new_op;
            error_flags   <= err;
          end
        end
        default: ;
      endcase
    end
  end

  // a_r/b_r hold operands of the current fold
  always_ff @(posedge clk) begin
    unique case (ctrl.cmd)
      CMD_OPER, CMD_FINAL: begin
        a_r   <= have_first ? running_value : '0;
        b_r   <= operand_value;
        mag_a <= running_value[W-1] ? W'(-running_value) : running_value;
        mag_b <= operand_value[W-1] ? W'(-operand_value) : operand_value;
        rem   <= '0;
        quo   <= '0;
        acc   <= one_w;
        mp    <= '0;
      end
      CMD_STEP: begin
        unique case (pending_op)
          OP_DIV, OP_MOD: begin
            if (!rem_sub[W]) begin
              rem <= rem_sub[W-1:0];
              quo <= {quo[W-2:0], 1'b1};
            end else begin
              rem <= rem_sh[W-1:0];
              quo <= {quo[W-2:0], 1'b0};
            end
          end
          OP_MUL, OP_POW: begin
            unique case (ctrl.phase)
              3'd0, 3'd3: mp <= pp;
              3'd1, 3'd4: mp <= mp_sum;
              PH_MUL_END: begin
                if (pending_op == OP_POW) sq <= W'(mp_sum);
                else acc <= W'(mp_sum);
              end
              PH_POW_END: acc <= b_r[bit_idx] ? W'(mp_sum) : sq;
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (pending_op)
      OP_ADD: result = a_r + b_r;
      OP_SUB: result = a_r - b_r;
      OP_MUL: result = acc;
      OP_DIV: result = (b_r == '0) ? '0 : ((a_neg != b_neg) ? W'(-quo) : quo);
      OP_MOD: result = (b_r == '0) ? '0 : (a_neg ? W'(-rem) : rem);
      OP_POW: begin
        if (b_neg) begin
          if (a_r == one_w) result = one_w;
          else if (a_r == all_ones) result = b_r[0] ? all_ones : one_w;
          else result = '0;
        end else begin
          result = acc;
        end
      end
      default: result = b_r;
    endcase
  end

  always_comb begin
    err = error_flags;
    if (have_first && b_r == '0 && error_flags == ST_OK) begin
      if (pending_op == OP_DIV) err = ST_DIV0;
      else if (pending_op == OP_MOD) err = ST_MOD0;
    end
  end

endmodule

// ===== hdl/ltrc_controller.sv =====
// Controller: sequences accept, fold iterations, and result transfer.
module ltrc_controller
  import ltrc_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       valid,
  output logic       ready,
  input  logic [7:0] char_code,
  input  logic       is_last,
  input  run_t       run_kind,
  output ctrl_t      ctrl,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       latch_out
);

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_RUN, S_DONE, S_OUT} state_t;

  localparam int STEPS = VALUE_WIDTH;

  state_t     state;
  logic [6:0] step;
  logic [2:0] phase;
  op_t        new_op;
  logic       last_r;
  logic       tail_r;
  logic       is_ws;
  logic       is_dig;
  op_t        op_in;
  logic       run_end;

  assign is_ws  = (char_code == CH_SPACE) ||
                  (char_code >= CH_TAB && char_code <= CH_CR);
  assign is_dig = (char_code >= CH_ZERO && char_code <= CH_NINE);
  assign op_in  = op_of(char_code);
  assign ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    unique case (run_kind)
      RUN_DIV: run_end = (step == 7'(STEPS - 1));
      RUN_MUL: run_end = (phase == PH_MUL_END);
      RUN_POW: run_end = (step == 7'(STEPS - 1)) && (phase == PH_POW_END);
      default: run_end = 1'b1;
    endcase
  end

  always_comb begin
    ctrl.cmd    = CMD_IDLE;
    ctrl.new_op = new_op;
    ctrl.step   = step;
    ctrl.phase  = phase;
    latch_out   = 1'b0;
    unique case (state)
      S_IDLE: if (valid) begin
        if (is_ws) ctrl.cmd = CMD_IDLE;
        else if (is_dig) ctrl.cmd = CMD_DIGIT;
        else if (op_in != OP_NONE) ctrl.cmd = CMD_IDLE;
        else ctrl.cmd = CMD_BAD;
      end
      S_LOAD: ctrl.cmd = CMD_OPER;
      S_RUN:  ctrl.cmd = CMD_STEP;
      S_DONE: begin
        ctrl.cmd  = CMD_CLEAR;
        latch_out = last_r && !tail_r;
      end
      default: ctrl.cmd = CMD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      step   <= '0;
      phase  <= '0;
      new_op <= OP_NONE;
      last_r <= 1'b0;
      tail_r <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (valid) begin
          last_r <= is_last;
          tail_r <= is_last && (op_in != OP_NONE);
          new_op <= op_in;
          if (op_in != OP_NONE || is_last) state <= S_LOAD;
        end
        S_LOAD: begin
          step  <= '0;
          phase <= '0;
          state <= (run_kind == RUN_NONE) ? S_DONE : S_RUN;
        end
        S_RUN: begin
          if (run_end) state <= S_DONE;
          if (run_kind == RUN_POW) begin
            if (phase == PH_POW_END) begin
              phase <= '0;
              step  <= step + 7'd1;
            end else begin
              phase <= phase + 3'd1;
            end
          end else if (run_kind == RUN_MUL) begin
            phase <= phase + 3'd1;
          end else begin
            step <= step + 7'd1;
          end
        end
        S_DONE: begin
          if (tail_r) begin
            tail_r <= 1'b0;
            new_op <= OP_NONE;
            state  <= S_LOAD;
          end else begin
            state <= last_r ? S_OUT : S_IDLE;
          end
        end
        S_OUT:  if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/left_to_right_char_calculator_unit.sv =====
// Top level of the left-to-right character calculator.
// One character is taken per transfer. Spaces, digits and invalid characters
// are taken without a fold. An operator, or the character marked last, folds
// the pending operation through the shared iterative unit in the transfer,
// load, iteration and write-back steps: add, subtract and a lone operand need
// no iteration, multiply forms three 32-bit partial products, divide and
// modulo form VALUE_WIDTH quotient bits (one quotient bit per cycle), and
// power forms a square and a multiply of three partial products each per
// exponent bit. An operator marked last folds twice, the second time against
// a zero operand. The result of the last character is held in an output
// register until it is taken, and no character is taken while it waits.
module left_to_right_char_calculator_unit
  import ltrc_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         char_code,
  input  logic               is_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] value,
  output logic [1:0]         status
);

  ctrl_t                  ctrl;
  run_t                   run_kind;
  logic                   latch_out;
  logic [VALUE_WIDTH-1:0] result;
  logic [1:0]             err;

  ltrc_controller #(.VALUE_WIDTH(VALUE_WIDTH)) u_ctrl (
    .clk, .rst, .valid(in_valid), .ready(in_ready), .char_code, .is_last,
    .run_kind, .ctrl, .out_valid, .out_ready, .latch_out
  );

  ltrc_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk, .rst, .ctrl, .char_code, .result, .err, .run_kind
  );

  always_ff @(posedge clk) begin
    if (latch_out) begin
      value  <= 64'($signed(result));
      status <= err;
    end
  end

endmodule

// ===== hdl/ltrc_checker.sv =====
// Port checker for the calculator, bound to the top level.
module ltrc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] value,
  input logic [1:0]  status
);

  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input ready while result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(status))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("result after reset");

  a_done_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> in_ready) else $error("not ready after transfer");

endmodule

bind left_to_right_char_calculator_unit ltrc_checker u_chk (
  .clk, .rst, .in_ready, .out_valid, .out_ready, .value, .status
);

// ===== bench/tb_top.sv =====
// Testbench for the left-to-right character calculator: random and directed expressions.
`timescale 1ns / 1ps
module tb_top;
  import ltrc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] char_code = 8'd0;
  logic is_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [63:0] value;
  logic [1:0] status;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  typedef struct {
    logic [63:0] val;
    logic [1:0]  st;
  } calc_result_t;

  char_item_t   pending_chars[$];
  calc_result_t expected_results[$];
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_send = 1'b0;
  bit  failed = 1'b0;
  bit  in_fire = 1'b0;

  logic [63:0] acc_val;
  logic [63:0] opnd_val;
  op_t         cur_op;
  bit          have_first;
  logic [1:0]  err_code;

  left_to_right_char_calculator_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .char_code(char_code), .is_last(is_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .value(value), .status(status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic bit is_neg(logic [63:0] x);
    return x[63];
  endfunction

  function automatic logic [63:0] magnitude(logic [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  function automatic logic [63:0] int_power(logic [63:0] b, logic [63:0] e);
    logic [63:0] r;
    r = 64'd1;
    if (e[63]) begin
      if (b == 64'd1) return 64'd1;
      if (b == '1) return e[0] ? '1 : 64'd1;
      return 64'd0;
    end
    for (int i = 63; i >= 0; i--) begin
      r = r * r;
      if (e[i]) r = r * b;
    end
    return r;
  endfunction

  function automatic void note_error(logic [1:0] code);
    if (err_code == ST_OK) err_code = code;
  endfunction

  function automatic logic [63:0] fold(logic [63:0] a, op_t op, logic [63:0] b);
    logic [63:0] q;
    case (op)
      OP_ADD: return a + b;
      OP_SUB: return a - b;
      OP_MUL: return a * b;
      OP_DIV: begin
        if (b == 0) begin
          note_error(ST_DIV0);
          return 64'd0;
        end
        q = magnitude(a) / magnitude(b);
        return (is_neg(a) != is_neg(b)) ? (64'd0 - q) : q;
      end
      OP_MOD: begin
        if (b == 0) begin
          note_error(ST_MOD0);
          return 64'd0;
        end
        q = magnitude(a) % magnitude(b);
        return is_neg(a) ? (64'd0 - q) : q;
      end
      OP_POW: return int_power(a, b);
      default: return b;
    endcase
  endfunction

  function automatic void clear_calc();
    acc_val = 0;
    opnd_val = 0;
    cur_op = OP_NONE;
    have_first = 1'b0;
    err_code = ST_OK;
  endfunction

  function automatic void eval_char(logic [7:0] c, logic last);
    calc_result_t r;
    op_t op;
    op = op_of(c);
    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      opnd_val = opnd_val * 64'd10 + 64'(c - CH_ZERO);
    end else if (op != OP_NONE) begin
      acc_val = have_first ? fold(acc_val, cur_op, opnd_val) : opnd_val;
      have_first = 1'b1;
      cur_op = op;
      opnd_val = 0;
    end else begin
      note_error(ST_BADCHAR);
    end
    if (last) begin
      r.val = have_first ? fold(acc_val, cur_op, opnd_val) : opnd_val;
      r.st = err_code;
      expected_results.push_back(r);
      clear_calc();
    end
  endfunction

  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_fire) begin
        if (pending_chars.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          char_code <= pending_chars[0].ch;
          is_last <= pending_chars[0].last;
          in_valid <= 1'b1;
          void'(pending_chars.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    calc_result_t e;
    in_fire = !rst && in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) eval_char(char_code, is_last);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result value=%0d status=%0d", value, status);
          failed = 1'b1;
        end else begin
          e = expected_results.pop_front();
          if (value !== e.val) begin
            $error("value expected %0d actual %0d", $signed(e.val), value);
            failed = 1'b1;
          end
          if (status !== e.st) begin
            $error("status expected %0d actual %0d", e.st, status);
            failed = 1'b1;
          end
        end
      end
    end
  end

  task automatic push_expr(string s);
    char_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.ch = s[i];
      it.last = (i == s.len() - 1);
      pending_chars.push_back(it);
    end
  endtask

  task automatic push_char(logic [7:0] c, logic last);
    char_item_t it;
    it.ch = c;
    it.last = last;
    pending_chars.push_back(it);
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_oper();
    logic [7:0] ops[6];
    ops = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_CARET};
    return ops[$urandom_range(5)];
  endfunction

  task automatic push_random_expr();
    int nterms;
    int ndig;
    logic [7:0] c;
    nterms = $urandom_range(1, 4);
    for (int t = 0; t < nterms; t++) begin
      if (t > 0) push_char(rand_oper(), 1'b0);
      ndig = ($urandom_range(9) == 0) ? $urandom_range(0, 21) : $urandom_range(0, 3);
      for (int d = 0; d < ndig; d++) push_char(rand_digit(), 1'b0);
      if ($urandom_range(9) == 0) push_char(CH_SPACE, 1'b0);
      if ($urandom_range(19) == 0) begin
        c = 8'($urandom_range(255));
        push_char(c, 1'b0);
      end
    end
    if ($urandom_range(4) == 0) c = 8'($urandom_range(255));
    else c = rand_digit();
    push_char(c, 1'b1);
  endtask

  task automatic drain();
    while (pending_chars.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    clear_calc();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    push_expr("7");
    push_expr("-5");
    push_expr("2+");
    push_expr("2+*3");
    push_expr("2 3");
    push_expr("8/0");
    push_expr("8%0");
    push_expr("9223372036854775807+1");
    push_expr("0-9223372036854775808/0-1");
    push_expr("0-7/2%3");
    push_expr("2^63");
    push_expr("3^0");
    push_expr("0-1^0-3");
    push_expr("5^0-1");
    push_expr("1^0-2");
    push_expr("12*3-4\t");
    push_expr("4#2");
    push_char(8'h00, 1'b0);
    push_char(8'hFF, 1'b1);
    push_char(CH_SPACE, 1'b1);
    push_expr("99999999999999999999*9");
    drain();

    hold_send = 1'b1;
    push_expr("6*7");
    repeat (20) @(posedge clk);
    hold_send = 1'b0;
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 28 : 46) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 28 : 46) : 0;
      for (int k = 0; k < 30; k++) push_random_expr();
      drain();
    end

    if (!failed) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
